/* rtl/acwg_pkg.sv */
package acwg_pkg;

	localparam int MAX_TASKS       = 64;
	localparam int COMPONENT_TYPES = 256;

	localparam int ID_W      = 8;
	localparam int WORD_W    = 64;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int ROWS      = (2 ** ID_W) / WORD_W;
	localparam int ROW_W     = ID_W - BIT_W;
	localparam int TASK_W    = 6;
	localparam int WAVE_W    = 6;
	localparam int COUNT_W   = 7;

	localparam int RES_MAX     = 3;
	localparam int RES_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	typedef enum logic [1:0] {
		MODE_READ,
		MODE_WRITE,
		MODE_BARRIER,
		MODE_END
	} mode_t;

	typedef enum logic {
		KIND_PLACE,
		KIND_CLOSE
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [TASK_W-1:0]   task_index;
		logic [WAVE_W-1:0]   wave_index;
		logic [COUNT_W-1:0]  member_count;
		logic                parallel;
		logic                rejected;
	} result_t;

	typedef struct packed {
		logic [RES_IDX_W-1:0]      count;
		result_t [RES_MAX-1:0]     res;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t bundle;
	} q_push_t;

	typedef struct packed {
		logic [WORD_W-1:0] wr;
		logic [WORD_W-1:0] ww;
		logic [WORD_W-1:0] pr;
		logic [WORD_W-1:0] pw;
	} row_t;

endpackage

/* rtl/acwg_out_queue.sv */
module acwg_out_queue import acwg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  q_push_t           push,
	output logic [QCNT_W-1:0] level,
	output logic              out_valid,
	output result_t           out_res,
	output logic              out_last,
	input  logic              out_stall
);

	bundle_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0]    cnt_q;
	logic [RES_IDX_W-1:0] sub_q;
	bundle_t              head;
	logic                 beat;
	logic                 pop;

	assign head      = slot_q[rd_ptr_q];
	assign out_valid = (cnt_q != '0);
	assign out_res   = head.res[sub_q];
	assign out_last  = (sub_q == head.count - RES_IDX_W'(1));
	assign beat      = out_valid && !out_stall;
	assign pop       = beat && out_last;
	assign level     = cnt_q;

	always_ff @(posedge clk) begin
		if (push.push) begin
			slot_q[wr_ptr_q] <= push.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sub_q    <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.push) - QCNT_W'(pop);
			if (beat) begin
				sub_q <= out_last ? '0 : sub_q + RES_IDX_W'(1);
			end
		end
	end

endmodule

/* rtl/access_conflict_wave_grouper_top.sv */
// Access-conflict wave grouper.
// Tasks arrive on the item channel as runs of read and write access beats
// (mode, component_id, last_access); a barrier beat is a task with no
// accesses and an end beat closes the list. Results leave on the result
// channel, one beat per result, with last set on the final result that an
// item causes: a task placement or rejection, and wave closures.
// An item is taken at a rising edge with item_valid high and item_stall low.
// Its access sets row is read from the state memory at that edge and the
// work is done in the following cycle, where the row is written back; a
// forwarding register covers an item that follows at once on the same row.
// The first result beat is valid from the edge that ends that work cycle,
// where the bundle enters the result queue. Throughput is one item per
// cycle while each item gives at most one result and result_stall is low;
// items that give two or three results are limited by the one-beat-per-cycle
// result port, and a queue of four result bundles lets the item side run on
// while result_stall holds the output. item_stall rises when that queue
// could not take the items in flight. Reset clears every wave and pending
// flag, the counters and the queue; no memory clearing pass is needed.
module access_conflict_wave_grouper_top import acwg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          mode,
	input  logic [ID_W-1:0]     component_id,
	input  logic                last_access,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                kind,
	output logic [TASK_W-1:0]   task_index,
	output logic [WAVE_W-1:0]   wave_index,
	output logic [COUNT_W-1:0]  member_count,
	output logic                parallel,
	output logic                rejected,
	output logic                last
);

	row_t                 state_mem [ROWS];
	row_t                 rdata_s1;
	logic                 valid_s1;
	mode_t                mode_s1;
	logic [ID_W-1:0]      id_s1;
	logic                 last_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [BIT_W-1:0]     bit_s1;

	logic                 fwd_v_q;
	logic [ROW_W-1:0]     fwd_row_q;
	row_t                 fwd_data_q;

	logic [ROWS-1:0]      wave_v_q;
	logic [ROWS-1:0]      merge_q;
	logic [ROWS-1:0]      pend_v_q;
	logic                 pconf_q;
	logic [COUNT_W-1:0]   tasks_q;
	logic [WAVE_W-1:0]    wave_q;
	logic [COUNT_W-1:0]   members_q;

	logic [ROWS-1:0]      wave_v_n;
	logic [ROWS-1:0]      merge_n;
	logic [ROWS-1:0]      pend_v_n;
	logic                 pconf_n;
	logic [COUNT_W-1:0]   tasks_n;
	logic [WAVE_W-1:0]    wave_n;
	logic [COUNT_W-1:0]   members_n;

	logic                 accept;
	logic                 fwd_hit;
	row_t                 raw;
	row_t                 eff;
	row_t                 wdata;
	logic [WORD_W-1:0]    one_hot;
	logic                 in_range;
	logic                 is_access;
	logic                 hit;
	logic                 mem_we;
	logic                 conflict;
	logic                 task_full;
	logic [RES_IDX_W-1:0] n;
	q_push_t              q_push;
	logic [QCNT_W-1:0]    q_level;
	result_t              out_res;

	function automatic result_t mk_close(logic [WAVE_W-1:0] w, logic [COUNT_W-1:0] m);
		result_t r;
		r              = '0;
		r.kind         = KIND_CLOSE;
		r.wave_index   = w;
		r.member_count = m;
		r.parallel     = (m > COUNT_W'(1));
		return r;
	endfunction

	function automatic result_t mk_place(logic [TASK_W-1:0] t, logic [WAVE_W-1:0] w);
		result_t r;
		r            = '0;
		r.kind       = KIND_PLACE;
		r.task_index = t;
		r.wave_index = w;
		return r;
	endfunction

	function automatic result_t mk_reject();
		result_t r;
		r          = '0;
		r.kind     = KIND_PLACE;
		r.rejected = 1'b1;
		return r;
	endfunction

	assign item_stall = ((q_level + QCNT_W'(valid_s1)) >= QCNT_W'(QUEUE_DEPTH));
	assign accept     = item_valid && !item_stall;
	assign row_s1     = id_s1[ID_W-1:BIT_W];
	assign bit_s1     = id_s1[BIT_W-1:0];
	assign fwd_hit    = fwd_v_q && (fwd_row_q == row_s1);

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= state_mem[component_id[ID_W-1:BIT_W]];
		end
		if (mem_we) begin
			state_mem[row_s1] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_t'(mode);
			id_s1   <= component_id;
			last_s1 <= last_access;
		end
		fwd_row_q  <= row_s1;
		fwd_data_q <= wdata;
	end

	always_comb begin
		raw     = fwd_hit ? fwd_data_q : rdata_s1;
		one_hot = {{(WORD_W-1){1'b0}}, 1'b1} << bit_s1;
		eff.wr  = (wave_v_q[row_s1] ? raw.wr : '0) | (merge_q[row_s1] ? raw.pr : '0);
		eff.ww  = (wave_v_q[row_s1] ? raw.ww : '0) | (merge_q[row_s1] ? raw.pw : '0);
		eff.pr  = pend_v_q[row_s1] ? raw.pr : '0;
		eff.pw  = pend_v_q[row_s1] ? raw.pw : '0;
		is_access = (mode_s1 == MODE_READ) || (mode_s1 == MODE_WRITE);
		in_range  = (int'(id_s1) < COMPONENT_TYPES);
		if (mode_s1 == MODE_READ) begin
			hit = eff.ww[bit_s1];
		end else begin
			hit = eff.ww[bit_s1] | eff.wr[bit_s1];
		end
		wdata = eff;
		if (mode_s1 == MODE_READ) begin
			wdata.pr = eff.pr | one_hot;
		end else begin
			wdata.pw = eff.pw | one_hot;
		end
		mem_we = valid_s1 && is_access && in_range;
	end

	always_comb begin
		wave_v_n  = wave_v_q;
		merge_n   = merge_q;
		pend_v_n  = pend_v_q;
		pconf_n   = pconf_q;
		tasks_n   = tasks_q;
		wave_n    = wave_q;
		members_n = members_q;
		q_push    = '0;
		n         = '0;
		conflict  = pconf_q | (mem_we & hit);
		task_full = (tasks_q >= COUNT_W'(MAX_TASKS));
		if (valid_s1) begin
			case (mode_s1)
				MODE_READ, MODE_WRITE: begin
					if (mem_we) begin
						wave_v_n[row_s1] = 1'b1;
						merge_n[row_s1]  = 1'b0;
						pend_v_n[row_s1] = 1'b1;
					end
					if (!last_s1) begin
						pconf_n = conflict;
					end else begin
						pconf_n = 1'b0;
						if (task_full) begin
							q_push.bundle.res[n] = mk_reject();
							n = n + RES_IDX_W'(1);
							pend_v_n = '0;
						end else begin
							if (conflict && (members_q != '0)) begin
								q_push.bundle.res[n] = mk_close(wave_n, members_n);
								n = n + RES_IDX_W'(1);
								wave_n    = wave_n + WAVE_W'(1);
								members_n = '0;
								wave_v_n  = '0;
								merge_n   = '0;
							end
							q_push.bundle.res[n] = mk_place(tasks_q[TASK_W-1:0], wave_n);
							n = n + RES_IDX_W'(1);
							members_n = members_n + COUNT_W'(1);
							tasks_n   = tasks_q + COUNT_W'(1);
							merge_n   = merge_n | pend_v_n;
							pend_v_n  = '0;
						end
					end
				end
				MODE_BARRIER: begin
					pconf_n  = 1'b0;
					pend_v_n = '0;
					if (task_full) begin
						q_push.bundle.res[n] = mk_reject();
						n = n + RES_IDX_W'(1);
					end else begin
						if (members_q != '0) begin
							q_push.bundle.res[n] = mk_close(wave_n, members_n);
							n = n + RES_IDX_W'(1);
							wave_n = wave_n + WAVE_W'(1);
						end
						q_push.bundle.res[n] = mk_place(tasks_q[TASK_W-1:0], wave_n);
						n = n + RES_IDX_W'(1);
						tasks_n = tasks_q + COUNT_W'(1);
						q_push.bundle.res[n] = mk_close(wave_n, COUNT_W'(1));
						n = n + RES_IDX_W'(1);
						wave_n    = wave_n + WAVE_W'(1);
						members_n = '0;
						wave_v_n  = '0;
						merge_n   = '0;
					end
				end
				MODE_END: begin
					if (members_q != '0) begin
						q_push.bundle.res[n] = mk_close(wave_q, members_q);
						n = n + RES_IDX_W'(1);
					end
					pconf_n   = 1'b0;
					pend_v_n  = '0;
					wave_v_n  = '0;
					merge_n   = '0;
					tasks_n   = '0;
					wave_n    = '0;
					members_n = '0;
				end
				default: begin
					pconf_n = pconf_q;
				end
			endcase
		end
		q_push.bundle.count = n;
		q_push.push         = valid_s1 && (n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_v_q   <= 1'b0;
			wave_v_q  <= '0;
			merge_q   <= '0;
			pend_v_q  <= '0;
			pconf_q   <= 1'b0;
			tasks_q   <= '0;
			wave_q    <= '0;
			members_q <= '0;
		end else begin
			valid_s1  <= accept;
			fwd_v_q   <= mem_we;
			wave_v_q  <= wave_v_n;
			merge_q   <= merge_n;
			pend_v_q  <= pend_v_n;
			pconf_q   <= pconf_n;
			tasks_q   <= tasks_n;
			wave_q    <= wave_n;
			members_q <= members_n;
		end
	end

	acwg_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.level     (q_level),
		.out_valid (result_valid),
		.out_res   (out_res),
		.out_last  (last),
		.out_stall (result_stall)
	);

	assign kind         = out_res.kind;
	assign task_index   = out_res.task_index;
	assign wave_index   = out_res.wave_index;
	assign member_count = out_res.member_count;
	assign parallel     = out_res.parallel;
	assign rejected     = out_res.rejected;

	// A row's pending half is either still pending or already merged into the wave.
	a_merge_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(merge_q & pend_v_q) == '0)
		else $error("row both pending and merged");

	a_tasks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		tasks_q <= COUNT_W'(MAX_TASKS))
		else $error("task count beyond limit");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.push |-> (q_level < QCNT_W'(QUEUE_DEPTH)))
		else $error("result queue overflow");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (mode_s1 == MODE_END)) |=>
		((tasks_q == '0) && (members_q == '0) && (wave_q == '0) && (wave_v_q == '0)))
		else $error("end of list did not clear state");

endmodule
